>>> rtl/cmdp_pkg.sv
// Shared types, constants and helpers for the command line parser.
// No dependencies; imported by every module of the block.
package cmdp_pkg;

  // Magnitude range of one parsed number; the output always carries 32 bits.
  localparam int VALUE_BITS = 32;
  localparam int OUT_W      = 32;
  localparam int CALC_W     = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;
  localparam int NUM_FIELDS = 3;

  localparam logic [2:0] PREFIX_LEN = 3'd6;
  localparam logic [4:0] SET_LENGTH = 5'd17;
  localparam logic [4:0] DEF_LENGTH = 5'd8;
  localparam logic [4:0] LEN_CAP    = 5'd18;
  localparam logic [7:0] END_RESET  = 8'd62;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [1:0] {
    ST_NOCMD     = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OK        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CT_NONE = 2'd0,
    CT_SET  = 2'd1,
    CT_DEF  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    TT_EMPTY = 3'd0,
    TT_S     = 3'd1,
    TT_SE    = 3'd2,
    TT_SET   = 3'd3,
    TT_D     = 3'd4,
    TT_DE    = 3'd5,
    TT_DEF   = 3'd6,
    TT_OTHER = 3'd7
  } type_e;

  // Per-field update request from the line tracker.
  typedef struct packed {
    logic       clr;
    logic       sign_we;
    logic       neg;
    logic       digit_we;
    logic [3:0] digit;
  } fld_ctrl_t;

  typedef struct packed {
    status_e          status;
    cmd_e             cmd;
    logic [OUT_W-1:0] voltage;
    logic [OUT_W-1:0] current;
    logic [OUT_W-1:0] protection;
  } res_t;

  function automatic logic [7:0] prefix_byte(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h3c;  // '<'
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h46;
      3'd4:    c = 8'h50;
      3'd5:    c = CH_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

>>> rtl/cmdp_field.sv
// One number field: saturating decimal accumulator plus sign.
// Depends on cmdp_pkg.
module cmdp_field (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmdp_pkg::fld_ctrl_t      ctrl_i,
  output logic [cmdp_pkg::OUT_W-1:0] value_o
);
  import cmdp_pkg::*;

  localparam int ACC_W = VALUE_BITS + 4;
  localparam logic [ACC_W-1:0] CAP = ACC_W'(1) << (VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [ACC_W-1:0]      acc;
  logic [CALC_W-1:0]     mag_ext;
  logic [CALC_W-1:0]     pos_val;
  logic [CALC_W-1:0]     neg_val;

  // 10*m + d; saturate when above the cap (magnitude never exceeds the cap)
  assign acc = (ACC_W'(mag_q) << 3) + (ACC_W'(mag_q) << 1) + ACC_W'(ctrl_i.digit);

  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    if (ctrl_i.clr) begin
      mag_d = '0;
      neg_d = 1'b0;
    end else begin
      if (ctrl_i.sign_we) neg_d = ctrl_i.neg;
      if (ctrl_i.digit_we) begin
        mag_d = (acc > CAP) ? VALUE_BITS'(CAP) : acc[VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
      neg_q <= 1'b0;
    end else begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  assign mag_ext = CALC_W'(mag_q);
  assign neg_val = CALC_W'(0) - mag_ext;
  assign pos_val = (ACC_W'(mag_q) >= CAP) ? CALC_W'(CAP - ACC_W'(1)) : mag_ext;
  assign value_o = neg_q ? neg_val[OUT_W-1:0] : pos_val[OUT_W-1:0];

endmodule

>>> rtl/cmdp_tracker.sv
// Line state: prefix match, body length, type recognizer, commas, number phase.
// Judges the line at the terminator. Depends on cmdp_pkg.
module cmdp_tracker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     step_i,
  input  logic [7:0]                               byte_i,
  input  logic [7:0]                               end_char_i,
  input  logic [cmdp_pkg::NUM_FIELDS-1:0][cmdp_pkg::OUT_W-1:0] fld_value_i,
  output logic                                     term_o,
  output cmdp_pkg::fld_ctrl_t [cmdp_pkg::NUM_FIELDS-1:0] fld_ctrl_o,
  output cmdp_pkg::res_t                           res_o
);
  import cmdp_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic       failed_q, failed_d;
  logic [4:0] len_q, len_d;
  type_e      tt_q, tt_d;
  logic [1:0] cc_q, cc_d;
  phase_e     ph_q, ph_d;
  logic [1:0] fsel;
  logic       is_digit;

  assign term_o   = (byte_i == end_char_i);
  assign fsel     = cc_q - 2'd1;
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);

  always_comb begin
    pos_d      = pos_q;
    failed_d   = failed_q;
    len_d      = len_q;
    tt_d       = tt_q;
    cc_d       = cc_q;
    ph_d       = ph_q;
    fld_ctrl_o = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      fld_ctrl_o[i].digit = 4'(byte_i - CH_ZERO);
    end
    if (step_i) begin
      if (term_o) begin
        pos_d    = '0;
        failed_d = 1'b0;
        len_d    = '0;
        tt_d     = TT_EMPTY;
        cc_d     = '0;
        ph_d     = PH_SKIP;
        for (int i = 0; i < NUM_FIELDS; i++) fld_ctrl_o[i].clr = 1'b1;
      end else if (!failed_q) begin
        if (pos_q < PREFIX_LEN) begin
          if (byte_i == prefix_byte(pos_q)) pos_d = pos_q + 3'd1;
          else failed_d = 1'b1;
        end else begin
          if (len_q < LEN_CAP) len_d = len_q + 5'd1;
          if (byte_i == CH_COMMA) begin
            if (cc_q == 2'd0) begin
              if (tt_q != TT_SET && tt_q != TT_DEF) tt_d = TT_OTHER;
              cc_d = 2'd1;
              ph_d = PH_SKIP;
            end else if (cc_q != 2'd3) begin
              cc_d = cc_q + 2'd1;
              ph_d = PH_SKIP;
            end else begin
              ph_d = PH_DONE;
            end
          end else if (cc_q == 2'd0) begin
            case (tt_q)
              TT_EMPTY: tt_d = (byte_i == CH_S) ? TT_S :
                               (byte_i == CH_D) ? TT_D : TT_OTHER;
              TT_S:     tt_d = (byte_i == CH_E) ? TT_SE  : TT_OTHER;
              TT_SE:    tt_d = (byte_i == CH_T) ? TT_SET : TT_OTHER;
              TT_D:     tt_d = (byte_i == CH_E) ? TT_DE  : TT_OTHER;
              TT_DE:    tt_d = (byte_i == CH_F) ? TT_DEF : TT_OTHER;
              default:  tt_d = TT_OTHER;
            endcase
          end else if (ph_q == PH_SKIP && is_space(byte_i)) begin
            // leading whitespace
          end else if (ph_q == PH_SKIP && (byte_i == CH_PLUS || byte_i == CH_MINUS)) begin
            ph_d                   = PH_DIGITS;
            fld_ctrl_o[fsel].sign_we = 1'b1;
            fld_ctrl_o[fsel].neg     = (byte_i == CH_MINUS);
          end else if (ph_q != PH_DONE) begin
            if (is_digit) begin
              ph_d                      = PH_DIGITS;
              fld_ctrl_o[fsel].digit_we = 1'b1;
            end else begin
              ph_d = PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      failed_q <= 1'b0;
      len_q    <= '0;
      tt_q     <= TT_EMPTY;
      cc_q     <= '0;
      ph_q     <= PH_SKIP;
    end else begin
      pos_q    <= pos_d;
      failed_q <= failed_d;
      len_q    <= len_d;
      tt_q     <= tt_d;
      cc_q     <= cc_d;
      ph_q     <= ph_d;
    end
  end

  // verdict on the line held so far
  always_comb begin
    res_o = '{status: ST_NOCMD, cmd: CT_NONE, voltage: '0, current: '0, protection: '0};
    if (!failed_q && pos_q == PREFIX_LEN) begin
      if (tt_q == TT_SET) begin
        res_o.cmd = CT_SET;
        if (cc_q == 2'd3 && len_q == SET_LENGTH) begin
          res_o.status     = ST_OK;
          res_o.voltage    = fld_value_i[0];
          res_o.current    = fld_value_i[1];
          res_o.protection = fld_value_i[2];
        end else begin
          res_o.status = ST_MALFORMED;
        end
      end else if (tt_q == TT_DEF) begin
        res_o.cmd = CT_DEF;
        if (len_q == DEF_LENGTH) begin
          res_o.status  = ST_OK;
          res_o.voltage = fld_value_i[0];
        end else begin
          res_o.status = ST_MALFORMED;
        end
      end else begin
        res_o.status = ST_UNKNOWN;
      end
    end
  end

endmodule

>>> rtl/text_command_line_parser.sv
// Channel  | signals                                   | dir
// rx       | rx_valid_i rx_ready_o rx_byte_i            | in
// res      | res_valid_o res_ready_i status_o cmd_type_o| out
//          | voltage_o current_o protection_o          |
// cfg      | cfg_valid_i cfg_ready_o cfg_data_i         | in (end_char)
//
// One byte per cycle: input register, then line state update; a terminator
// loads the result register, whose contents are then offered on the res channel.
// The input side stalls only when a terminator meets a result register still full.
// Reset: async active low, clears line state, sets end_char to '>'.
// Depends on cmdp_pkg, cmdp_tracker, cmdp_field.
module text_command_line_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [1:0]         status_o,
  output logic [1:0]         cmd_type_o,
  output logic signed [31:0] voltage_o,
  output logic signed [31:0] current_o,
  output logic signed [31:0] protection_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);
  import cmdp_pkg::*;

  logic [7:0] end_char_q;
  logic [7:0] byte_q;
  logic       in_valid_q, in_valid_d;
  logic       out_valid_q, out_valid_d;
  res_t       res_q;
  res_t       res;
  logic       term;
  logic       step;
  fld_ctrl_t [NUM_FIELDS-1:0]             fld_ctrl;
  logic [NUM_FIELDS-1:0][OUT_W-1:0]      fld_value;

  assign cfg_ready_o = 1'b1;

  assign step       = in_valid_q && !(term && out_valid_q && !res_ready_i);
  assign rx_ready_o = !in_valid_q || step;
  assign in_valid_d = (rx_valid_i && rx_ready_o) || (in_valid_q && !step);
  assign out_valid_d = (out_valid_q && !res_ready_i) || (step && term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_char_q  <= END_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) end_char_q <= cfg_data_i;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) byte_q <= rx_byte_i;
    if (step && term) res_q <= res;
  end

  cmdp_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .end_char_i  (end_char_q),
    .fld_value_i (fld_value),
    .term_o      (term),
    .fld_ctrl_o  (fld_ctrl),
    .res_o       (res)
  );

  for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_field
    cmdp_field u_field (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (fld_ctrl[g]),
      .value_o (fld_value[g])
    );
  end

  assign res_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign cmd_type_o   = res_q.cmd;
  assign voltage_o    = res_q.voltage;
  assign current_o    = res_q.current;
  assign protection_o = res_q.protection;

endmodule

>>> rtl/cmdp_checker.sv
// Port-level checks for the command line parser, bound to the top level.
// Depends on cmdp_pkg and text_command_line_parser.
module cmdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_o,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic [1:0]  status_o,
  input logic [1:0]  cmd_type_o,
  input logic [31:0] voltage_o,
  input logic [31:0] current_o,
  input logic [31:0] protection_o
);
  import cmdp_pkg::*;

  // result holds while stalled
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(status_o) && $stable(voltage_o))
    else $error("result beat changed while stalled");

  // input side stalls only behind a full result register
  a_rx_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> res_valid_o && !res_ready_i)
    else $error("rx stalled with result register free");

  a_zero_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_OK |->
      voltage_o == '0 && current_o == '0 && protection_o == '0)
    else $error("non-ok result carries values");

  a_def_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && cmd_type_o == CT_DEF |-> current_o == '0 && protection_o == '0)
    else $error("DEF result carries current or protection");

  a_no_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (status_o == ST_NOCMD || status_o == ST_UNKNOWN) |->
      cmd_type_o == CT_NONE)
    else $error("type set on non-command or unknown result");

endmodule

bind text_command_line_parser cmdp_checker u_cmdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_ready_o   (rx_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .status_o     (status_o),
  .cmd_type_o   (cmd_type_o),
  .voltage_o    (voltage_o),
  .current_o    (current_o),
  .protection_o (protection_o)
);

>>> dv/line_verdict_checker.sv
// Watches the byte, result and end-character channels of the command line parser,
// tracks each line byte by byte and compares every result beat with its prediction.
// Depends on cmdp_pkg for the field codes, the character constants and res_t.
`timescale 1ns / 100ps

module line_verdict_checker #(
  parameter logic [47:0] LINE_HEAD = 48'h3c_43_54_46_50_2c
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  input  logic               rx_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [1:0]         status_i,
  input  logic [1:0]         cmd_type_i,
  input  logic signed [31:0] voltage_i,
  input  logic signed [31:0] current_i,
  input  logic signed [31:0] protection_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import cmdp_pkg::*;

  localparam logic [63:0] MAG_CAP = 64'd1 << (VALUE_BITS - 1);

  logic [7:0]  end_char;
  logic [2:0]  head_pos;
  logic        head_broken;
  logic [4:0]  body_len;
  type_e       type_seen;
  logic [1:0]  commas;
  phase_e      num_phase;
  logic [63:0] magnitude [NUM_FIELDS];
  logic        negative [NUM_FIELDS];

  res_t expected_verdicts[$];

  function automatic logic blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic type_e next_type(input type_e t, input logic [7:0] c);
    if (t == TT_EMPTY && c == CH_S) return TT_S;
    if (t == TT_S && c == CH_E) return TT_SE;
    if (t == TT_SE && c == CH_T) return TT_SET;
    if (t == TT_EMPTY && c == CH_D) return TT_D;
    if (t == TT_D && c == CH_E) return TT_DE;
    if (t == TT_DE && c == CH_F) return TT_DEF;
    return TT_OTHER;
  endfunction

  // Saturated value of one number, as the 32-bit output word.
  function automatic logic [31:0] field_word(input int f);
    logic [63:0] v;
    if (negative[f]) v = 64'd0 - magnitude[f];
    else v = (magnitude[f] >= MAG_CAP) ? MAG_CAP - 64'd1 : magnitude[f];
    return v[31:0];
  endfunction

  task automatic clear_line();
    head_pos    = '0;
    head_broken = 1'b0;
    body_len    = '0;
    type_seen   = TT_EMPTY;
    commas      = '0;
    num_phase   = PH_SKIP;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      magnitude[i] = '0;
      negative[i]  = 1'b0;
    end
  endtask

  task automatic number_byte(input int f, input logic [7:0] c);
    logic [63:0] d;
    if (num_phase == PH_DONE) return;
    if (num_phase == PH_SKIP) begin
      if (blank(c)) return;
      num_phase = PH_DIGITS;
      if (c == CH_PLUS || c == CH_MINUS) begin
        negative[f] = (c == CH_MINUS);
        return;
      end
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 64'(c - CH_ZERO);
      if (magnitude[f] > (MAG_CAP - d) / 64'd10) magnitude[f] = MAG_CAP;
      else magnitude[f] = magnitude[f] * 64'd10 + d;
    end else begin
      num_phase = PH_DONE;
    end
  endtask

  task automatic body_byte(input logic [7:0] c);
    if (body_len < LEN_CAP) body_len++;
    if (c == CH_COMMA) begin
      if (commas == 2'd0) begin
        if (type_seen != TT_SET && type_seen != TT_DEF) type_seen = TT_OTHER;
        commas    = 2'd1;
        num_phase = PH_SKIP;
      end else if (commas < 2'd3) begin
        commas++;
        num_phase = PH_SKIP;
      end else begin
        // a comma past the third one closes the last number
        num_phase = PH_DONE;
      end
    end else if (commas == 2'd0) begin
      type_seen = next_type(type_seen, c);
    end else begin
      number_byte(int'(commas) - 1, c);
    end
  endtask

  task automatic judge_line();
    res_t v;
    v            = '0;
    v.status     = ST_NOCMD;
    v.cmd        = CT_NONE;
    if (!head_broken && head_pos == PREFIX_LEN) begin
      if (type_seen == TT_SET) begin
        v.cmd = CT_SET;
        if (commas == 2'd3 && body_len == SET_LENGTH) begin
          v.status     = ST_OK;
          v.voltage    = field_word(0);
          v.current    = field_word(1);
          v.protection = field_word(2);
        end else begin
          v.status = ST_MALFORMED;
        end
      end else if (type_seen == TT_DEF) begin
        v.cmd = CT_DEF;
        if (body_len == DEF_LENGTH) begin
          v.status  = ST_OK;
          v.voltage = field_word(0);
        end else begin
          v.status = ST_MALFORMED;
        end
      end else begin
        v.status = ST_UNKNOWN;
      end
    end
    expected_verdicts.push_back(v);
  endtask

  task automatic take_byte(input logic [7:0] c);
    if (c == end_char) begin
      judge_line();
      clear_line();
    end else if (!head_broken) begin
      if (head_pos < PREFIX_LEN) begin
        if (c == LINE_HEAD[47 - 8 * int'(head_pos) -: 8]) head_pos++;
        else head_broken = 1'b1;
      end else begin
        body_byte(c);
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_verdict();
    res_t v;
    if (expected_verdicts.size() == 0) begin
      $error("result beat with no line pending: status %0d", status_i);
      fail_count_o++;
      return;
    end
    v = expected_verdicts.pop_front();
    check_field("status", 32'(v.status), 32'(status_i));
    check_field("cmd_type", 32'(v.cmd), 32'(cmd_type_i));
    check_field("voltage", v.voltage, voltage_i);
    check_field("current", v.current, current_i);
    check_field("protection", v.protection, protection_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_char     = END_RESET;
      fail_count_o = 0;
      clear_line();
      expected_verdicts.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) end_char = cfg_data_i;
      if (rx_valid_i && rx_ready_i) take_byte(rx_byte_i);
      if (res_valid_i && res_ready_i) check_verdict();
      pending_o <= expected_verdicts.size();
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the command line parser bench: clock, reset, byte and end-character stimulus,
// result back-pressure and the verdict. Depends on cmdp_pkg, text_command_line_parser
// and line_verdict_checker.
`timescale 1ns / 100ps

module testbench;
  import cmdp_pkg::*;

  // '<', 'C', 'T', 'F', 'P', ','
  localparam logic [47:0] LINE_HEAD      = 48'h3c_43_54_46_50_2c;
  localparam int          PHASE_BYTES    = 200;
  localparam int          LONG_HOLD      = 400;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 3000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               rx_valid  = 1'b0;
  logic               rx_ready;
  logic [7:0]         rx_byte   = 8'h00;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [1:0]         status;
  logic [1:0]         cmd_type;
  logic signed [31:0] voltage;
  logic signed [31:0] current;
  logic signed [31:0] protection;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data  = 8'h00;

  int         fail_count;
  int         pending;
  int         total_bytes = 0;
  int         idle_cycles = 0;
  int         hold_req    = 0;
  bit         quiet       = 1'b0;
  logic [7:0] term        = END_RESET;
  logic [7:0] line_q[$];

  text_command_line_parser uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_valid_i   (rx_valid),
    .rx_ready_o   (rx_ready),
    .rx_byte_i    (rx_byte),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .status_o     (status),
    .cmd_type_o   (cmd_type),
    .voltage_o    (voltage),
    .current_o    (current),
    .protection_o (protection),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  line_verdict_checker #(.LINE_HEAD(LINE_HEAD)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_valid_i   (rx_valid),
    .rx_ready_i   (rx_ready),
    .rx_byte_i    (rx_byte),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .status_i     (status),
    .cmd_type_i   (cmd_type),
    .voltage_i    (voltage),
    .current_i    (current),
    .protection_i (protection),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // number-like text: digits, blanks, signs, commas and now and then anything
  function automatic logic [7:0] filler_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'(CH_ZERO + $urandom_range(0, 9));
    if (r < 70) return 8'h20;
    if (r < 74) return 8'($urandom_range(9, 13));
    if (r < 80) return CH_PLUS;
    if (r < 86) return CH_MINUS;
    if (r < 90) return CH_COMMA;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_head(input int n);
    for (int k = 0; k < n; k++) line_q.push_back(LINE_HEAD[47 - 8 * k -: 8]);
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) line_q.push_back(s[k]);
  endtask

  task automatic add_filler(input int n);
    for (int k = 0; k < n; k++) line_q.push_back(filler_char());
  endtask

  task automatic add_noise(input int n);
    for (int k = 0; k < n; k++) line_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    total_bytes++;
  endtask

  task automatic send_line();
    foreach (line_q[k]) send_byte(line_q[k]);
    send_byte(term);
    line_q.delete();
  endtask

  task automatic directed_line(input string body);
    add_head(6);
    add_text(body);
    send_line();
  endtask

  // one beat of the end-character register, only once the parser has drained
  task automatic write_end_char(input logic [7:0] v);
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    term = v;
  endtask

  // occasionally off by one byte in length
  task automatic bend_length();
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 1) == 0) void'(line_q.pop_back());
      else line_q.push_back(filler_char());
    end
  endtask

  task automatic random_line();
    int r;
    int n1;
    int n2;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // SET body of 17 bytes: the three number fields share 11 bytes
      n1 = $urandom_range(0, 11);
      n2 = $urandom_range(0, 11 - n1);
      add_head(6);
      add_text("SET,");
      add_filler(n1);
      line_q.push_back(CH_COMMA);
      add_filler(n2);
      line_q.push_back(CH_COMMA);
      add_filler(11 - n1 - n2);
      bend_length();
    end else if (r < 60) begin
      add_head(6);
      add_text("DEF,");
      add_filler(4);
      bend_length();
    end else if (r < 70) begin
      add_head(6);
      case ($urandom_range(0, 8))
        0: add_text("SE");
        1: add_text("SETT");
        2: add_text("DE");
        3: add_text("DEFF");
        4: add_text("S");
        5: add_text("D");
        6: add_text("SET");
        7: add_text("DEF");
        default: ;
      endcase
      repeat ($urandom_range(0, 6)) begin
        line_q.push_back(CH_COMMA);
        add_filler($urandom_range(0, 4));
      end
    end else if (r < 80) begin
      add_head($urandom_range(0, 5));
      add_noise(1);
      add_filler($urandom_range(0, 10));
    end else if (r < 90) begin
      add_noise($urandom_range(0, 30));
    end else begin
      add_head(6);
      add_noise($urandom_range(0, 25));
    end
    quiet = ($urandom_range(0, 9) == 0);
    send_line();
  endtask

  task automatic random_phase();
    int start;
    start = total_bytes;
    while (total_bytes - start < PHASE_BYTES) random_line();
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("text_command_line_parser test failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_line("SET,1234,-567,+89");
    directed_line("SET,99999999999,,");
    directed_line("SET,-9999999999,,");
    directed_line("SET,2147483648,,0");
    directed_line("SET,-2147483648,,");
    directed_line("SET, 42a,+ 7,-0,,");
    directed_line("SET,\t+1,\n-2, 3xxx");
    directed_line("DEF,2500");
    directed_line("DEF,4,99");
    directed_line("DEF,12345");
    directed_line("SET,1,2");
    directed_line("XYZ,1,2,3");
    directed_line("SETS,1,2,3");
    directed_line("");
    // raw zero and all-ones bytes inside the number
    add_head(6);
    add_text("DEF,");
    line_q.push_back(8'h00);
    line_q.push_back(8'hff);
    add_text("12");
    send_line();
    add_head(4);
    send_line();
    add_text("hello");
    send_line();
    send_line();

    // the receiver holds off while lines keep coming, so the parser backs up
    hold_req++;
    random_phase();
    write_end_char(8'h00);
    random_phase();
    write_end_char(8'hff);
    random_phase();
    write_end_char(CH_COMMA);
    random_phase();
    write_end_char(8'h0a);
    random_phase();
    write_end_char(8'($urandom_range(0, 255)));
    random_phase();
    write_end_char(END_RESET);
    random_phase();

    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_command_line_parser test passed");
    end else begin
      $display("text_command_line_parser test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cmdp_pkg.sv
rtl/cmdp_field.sv
rtl/cmdp_tracker.sv
rtl/text_command_line_parser.sv
rtl/cmdp_checker.sv
dv/line_verdict_checker.sv
dv/testbench.sv
